FILE: design/dwrpid_pkg.sv
package dwrpid_pkg;

   localparam int SPEED_W    = 16;
   localparam int DT_W       = 16;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 22;
   localparam int DUTY_W     = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;
   localparam int ERR_W      = 17;
   localparam int INTEG_W    = 23;

   // derivative divider: |error change| * 65536 over the interval
   localparam int DIVIDEND_W = 33;
   localparam int QUO_W      = 33;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P         = 3'd0,
      REG_GAIN_I         = 3'd1,
      REG_GAIN_D         = 3'd2,
      REG_INTEGRAL_LIMIT = 3'd3,
      REG_DUTY_BASE      = 3'd4,
      REG_TARGET_LEFT    = 3'd5,
      REG_TARGET_RIGHT   = 3'd6,
      REG_RUN_ENABLE     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [LIMIT_W-1:0] integral_limit;
      logic [DUTY_W-1:0]  duty_base;
   } lane_cfg_type;

   typedef struct packed {
      logic start;
      logic take;
      logic clear;
   } lane_ctrl_type;

   typedef struct packed {
      logic              done;
      logic [DUTY_W-1:0] duty;
   } lane_stat_type;

endpackage

FILE: design/dwrpid_if.sv
interface dwrpid_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [dwrpid_pkg::SPEED_W-1:0]  speed_left;
   logic signed [dwrpid_pkg::SPEED_W-1:0]  speed_right;
   logic        [dwrpid_pkg::DT_W-1:0]     interval;

   modport source(output valid, speed_left, speed_right, interval, input ready);
   modport sink(input valid, speed_left, speed_right, interval, output ready);
endinterface

interface dwrpid_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [dwrpid_pkg::DUTY_W-1:0]      duty_left;
   logic [dwrpid_pkg::DUTY_W-1:0]      duty_right;

   modport source(output valid, duty_left, duty_right, input ready);
   modport sink(input valid, duty_left, duty_right, output ready);
endinterface

interface dwrpid_csr_if;
   logic                                valid;
   logic                                ready;
   logic [dwrpid_pkg::CSR_IDX_W-1:0]    index;
   logic [dwrpid_pkg::CSR_DATA_W-1:0]   data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

FILE: design/dwrpid_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module dwrpid_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [dwrpid_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [dwrpid_pkg::DT_W-1:0]          divisor,
   output logic                                 busy,
   output logic [dwrpid_pkg::QUO_W-1:0]         quotient
);

   localparam int STEPS = dwrpid_pkg::DIVIDEND_W;
   localparam int CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

   logic                                busy_ff;
   logic [CNT_W-1:0]                    cnt_ff;
   logic [dwrpid_pkg::DT_W-1:0]         rem_ff;
   logic [dwrpid_pkg::DIVIDEND_W-1:0]   quo_ff;

   logic [dwrpid_pkg::DT_W:0]           rem_sh;
   logic                                ge;
   logic [dwrpid_pkg::DT_W:0]           rem_sub;

   assign rem_sh  = {rem_ff, quo_ff[dwrpid_pkg::DIVIDEND_W-1]};
   assign ge      = rem_sh >= {1'b0, divisor};
   assign rem_sub = rem_sh - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         quo_ff  <= dividend;
      end else if (busy_ff) begin
         rem_ff <= ge ? rem_sub[dwrpid_pkg::DT_W-1:0] : rem_sh[dwrpid_pkg::DT_W-1:0];
         quo_ff <= {quo_ff[dwrpid_pkg::DIVIDEND_W-2:0], ge};
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: design/dwrpid_lane.sv
// One wheel's PID step: shared multiplier sequenced over states,
// derivative divider running alongside.
module dwrpid_lane #(
   parameter int unsigned DUTY_TOP = 8191
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  dwrpid_pkg::lane_ctrl_type               ctrl,
   input  dwrpid_pkg::lane_cfg_type                cfg,
   input  logic signed [dwrpid_pkg::SPEED_W-1:0]   target,
   input  logic signed [dwrpid_pkg::SPEED_W-1:0]   speed,
   input  logic        [dwrpid_pkg::DT_W-1:0]      dt,
   output dwrpid_pkg::lane_stat_type               stat
);

   localparam int ERR_W   = dwrpid_pkg::ERR_W;
   localparam int INTEG_W = dwrpid_pkg::INTEG_W;
   localparam int OPA_W   = 32;
   localparam int PROD_W  = OPA_W + dwrpid_pkg::GAIN_W + 1;
   localparam int ACC_W   = PROD_W + 9;
   localparam int SUMI_W  = 28;
   localparam int QOUT_W  = ACC_W - 20;
   localparam int DSUM_W  = QOUT_W + 1;
   localparam int DUTY_W  = dwrpid_pkg::DUTY_W;

   localparam logic signed [DSUM_W-1:0] TOP_S   = DSUM_W'(DUTY_TOP);
   localparam logic signed [PROD_W-1:0] RND8    = PROD_W'(255);
   localparam logic signed [ACC_W-1:0]  RND20   = ACC_W'(1048575);
   localparam logic [dwrpid_pkg::QUO_W-1:0] QPOS_MAX = dwrpid_pkg::QUO_W'(32'h7FFF_FFFF);
   localparam logic [dwrpid_pkg::QUO_W-1:0] QNEG_MAX = dwrpid_pkg::QUO_W'(32'h8000_0000);

   typedef enum logic [3:0] {
      S_IDLE, S_MDT, S_INTEG, S_PI, S_IACC, S_DWAIT,
      S_MD, S_DACC, S_SUM, S_BASE, S_CLAMP, S_DONE
   } state_type;

   state_type                     state_ff;
   logic signed [ERR_W-1:0]       err_ff;
   logic signed [ERR_W-1:0]       prev_err_ff;
   logic signed [INTEG_W-1:0]     integ_sum_ff;
   logic                          diff_neg_ff;
   logic signed [OPA_W-1:0]       deriv_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [QOUT_W-1:0]      qout_ff;
   logic signed [DSUM_W-1:0]      dsum_ff;
   logic [DUTY_W-1:0]             duty_ff;

   logic                          target_pos;
   logic signed [ERR_W-1:0]       err_now;
   logic signed [ERR_W:0]         diff_now;
   logic [ERR_W-1:0]              diff_mag;
   logic                          div_start;
   logic                          div_busy;
   logic [dwrpid_pkg::QUO_W-1:0]  div_quo;

   logic signed [OPA_W-1:0]       opa;
   logic [dwrpid_pkg::GAIN_W-1:0] opb;
   logic signed [PROD_W-1:0]      prod_in;

   logic signed [PROD_W-1:0]      incr_full;
   logic signed [SUMI_W-1:0]      incr;
   logic signed [SUMI_W-1:0]      integ_raw;
   logic signed [SUMI_W-1:0]      lim_pos;
   logic signed [SUMI_W-1:0]      lim_neg;
   logic signed [SUMI_W-1:0]      integ_clamp;
   logic signed [ACC_W-1:0]       prod_sh;
   logic signed [ACC_W-1:0]       acc_rnd;
   logic signed [OPA_W-1:0]       deriv_sat;

   assign target_pos = !target[dwrpid_pkg::SPEED_W-1] && (target != '0);
   assign err_now    = ERR_W'(target) - ERR_W'(speed);
   assign diff_now   = (ERR_W+1)'(err_now) - (ERR_W+1)'(prev_err_ff);
   assign diff_mag   = diff_now[ERR_W] ? ERR_W'(-diff_now) : diff_now[ERR_W-1:0];
   assign div_start  = (state_ff == S_IDLE) && ctrl.start && target_pos && (dt != '0);

   dwrpid_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({diff_mag, 16'd0}),
      .divisor  (dt),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // one multiplier, operands picked per step
   always_comb begin
      opa = OPA_W'(err_ff);
      opb = dt;
      unique case (state_ff)
         S_MDT: begin
            opa = OPA_W'(err_ff);
            opb = dt;
         end
         S_INTEG: begin
            opa = OPA_W'(err_ff);
            opb = cfg.gain_p;
         end
         S_PI: begin
            opa = OPA_W'(integ_sum_ff);
            opb = cfg.gain_i;
         end
         S_MD: begin
            opa = deriv_ff;
            opb = cfg.gain_d;
         end
         default: begin
            opa = OPA_W'(err_ff);
            opb = dt;
         end
      endcase
   end

   assign prod_in = opa * $signed({1'b0, opb});

   // integral: (err*dt)/256 toward zero, then clamp
   assign incr_full   = prod_ff + (prod_ff[PROD_W-1] ? RND8 : '0);
   assign incr        = SUMI_W'(incr_full >>> 8);
   assign integ_raw   = SUMI_W'(integ_sum_ff) + incr;
   assign lim_pos     = $signed({6'd0, cfg.integral_limit});
   assign lim_neg     = -lim_pos;
   assign integ_clamp = (integ_raw > lim_pos) ? lim_pos :
                        (integ_raw < lim_neg) ? lim_neg : integ_raw;

   assign prod_sh = ACC_W'($signed({prod_ff, 8'd0}));
   assign acc_rnd = acc_ff + (acc_ff[ACC_W-1] ? RND20 : '0);

   always_comb begin
      if (diff_neg_ff) begin
         deriv_sat = (div_quo > QNEG_MAX) ? $signed(32'h8000_0000)
                                          : -$signed(div_quo[OPA_W-1:0]);
      end else begin
         deriv_sat = (div_quo > QPOS_MAX) ? $signed(32'h7FFF_FFFF)
                                          : $signed(div_quo[OPA_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         integ_sum_ff <= '0;
         prev_err_ff  <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (ctrl.start) begin
                  if (target_pos) begin
                     err_ff      <= err_now;
                     diff_neg_ff <= diff_now[ERR_W];
                     state_ff    <= S_MDT;
                  end else begin
                     integ_sum_ff <= '0;
                     prev_err_ff  <= '0;
                     duty_ff      <= '0;
                     state_ff     <= S_DONE;
                  end
               end
            end
            S_MDT: state_ff <= S_INTEG;
            S_INTEG: begin
               integ_sum_ff <= integ_clamp[INTEG_W-1:0];
               state_ff     <= S_PI;
            end
            S_PI: begin
               acc_ff   <= prod_sh;
               state_ff <= S_IACC;
            end
            S_IACC: begin
               acc_ff   <= acc_ff + ACC_W'(prod_ff);
               state_ff <= S_DWAIT;
            end
            S_DWAIT: begin
               if (dt == '0) begin
                  deriv_ff <= '0;
                  state_ff <= S_MD;
               end else if (!div_busy) begin
                  deriv_ff <= deriv_sat;
                  state_ff <= S_MD;
               end
            end
            S_MD: state_ff <= S_DACC;
            S_DACC: begin
               acc_ff   <= acc_ff + prod_sh;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               qout_ff     <= QOUT_W'(acc_rnd >>> 20);
               prev_err_ff <= err_ff;
               state_ff    <= S_BASE;
            end
            S_BASE: begin
               dsum_ff  <= DSUM_W'(qout_ff) + $signed({26'd0, cfg.duty_base});
               state_ff <= S_CLAMP;
            end
            S_CLAMP: begin
               if (dsum_ff[DSUM_W-1]) begin
                  duty_ff <= '0;
               end else if (dsum_ff > TOP_S) begin
                  duty_ff <= TOP_S[DUTY_W-1:0];
               end else begin
                  duty_ff <= dsum_ff[DUTY_W-1:0];
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (ctrl.take) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (ctrl.clear) begin
            integ_sum_ff <= '0;
            prev_err_ff  <= '0;
         end
      end
   end

   assign stat.done = (state_ff == S_DONE);
   assign stat.duty = duty_ff;

endmodule

FILE: design/dual_wheel_rpm_pid.sv
// Dual wheel speed PID controller. Each request carries both measured
// wheel speeds and the tick interval; with run_enable set it yields one
// response holding both PWM duties, with run_enable clear it is consumed
// and yields nothing. The two wheels run in two identical lanes side by
// side, and the response register joins their duties. With a nonzero
// interval and a positive target the response waits on the 33-step
// derivative divider in each lane; a zero interval skips the divider,
// and when both targets are zero or below both lanes go straight to
// done with zero duty. The next request is accepted the cycle after the
// duties move into the response register, so no new request is taken
// while one is in flight; a stalled response holds the next request off.
// Writing a target or run_enable clears both wheels' integral and
// previous error. Configuration is to be written by the user only while
// no request is in flight; the block itself does not enforce it.
module dual_wheel_rpm_pid #(
   parameter int unsigned DUTY_TOP = 8191
) (
   input  logic                 clock,
   input  logic                 reset,
   dwrpid_req_if.sink           req_if,
   dwrpid_rsp_if.source         rsp_if,
   dwrpid_csr_if.sink           csr_if
);

   // configuration registers
   dwrpid_pkg::lane_cfg_type                cfg_ff;
   logic signed [dwrpid_pkg::SPEED_W-1:0]   target_left_ff;
   logic signed [dwrpid_pkg::SPEED_W-1:0]   target_right_ff;
   logic                                    run_enable_ff;

   // request capture and sequencing
   logic                                    busy_ff;
   logic                                    start_ff;
   logic                                    clear_ff;
   logic signed [dwrpid_pkg::SPEED_W-1:0]   speed_left_ff;
   logic signed [dwrpid_pkg::SPEED_W-1:0]   speed_right_ff;
   logic [dwrpid_pkg::DT_W-1:0]             interval_ff;

   // response register
   logic                                    rsp_valid_ff;
   logic [dwrpid_pkg::DUTY_W-1:0]           duty_left_ff;
   logic [dwrpid_pkg::DUTY_W-1:0]           duty_right_ff;

   logic                                    csr_write;
   logic                                    req_take;
   logic                                    both_done;
   logic                                    rsp_free;
   logic                                    load_rsp;
   dwrpid_pkg::lane_ctrl_type               lane_ctrl;
   dwrpid_pkg::lane_stat_type               stat_left;
   dwrpid_pkg::lane_stat_type               stat_right;

   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid && csr_if.ready;

   assign req_if.ready = !busy_ff;
   assign req_take     = req_if.valid && req_if.ready;

   assign both_done = stat_left.done && stat_right.done;
   assign rsp_free  = !rsp_valid_ff || rsp_if.ready;
   assign load_rsp  = busy_ff && both_done && rsp_free;

   assign lane_ctrl.start = start_ff;
   assign lane_ctrl.take  = load_rsp;
   assign lane_ctrl.clear = clear_ff;

   // register file; target and enable writes also reset the loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= dwrpid_pkg::GAIN_W'(512);
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= '0;
         cfg_ff.integral_limit <= dwrpid_pkg::LIMIT_W'(1228800);
         cfg_ff.duty_base      <= dwrpid_pkg::DUTY_W'(1000);
         target_left_ff        <= '0;
         target_right_ff       <= '0;
         run_enable_ff         <= 1'b0;
         clear_ff              <= 1'b0;
      end else begin
         clear_ff <= 1'b0;
         if (csr_write) begin
            unique case (csr_if.index)
               dwrpid_pkg::REG_GAIN_P:
                  cfg_ff.gain_p <= csr_if.data[dwrpid_pkg::GAIN_W-1:0];
               dwrpid_pkg::REG_GAIN_I:
                  cfg_ff.gain_i <= csr_if.data[dwrpid_pkg::GAIN_W-1:0];
               dwrpid_pkg::REG_GAIN_D:
                  cfg_ff.gain_d <= csr_if.data[dwrpid_pkg::GAIN_W-1:0];
               dwrpid_pkg::REG_INTEGRAL_LIMIT:
                  cfg_ff.integral_limit <= csr_if.data[dwrpid_pkg::LIMIT_W-1:0];
               dwrpid_pkg::REG_DUTY_BASE:
                  cfg_ff.duty_base <= csr_if.data[dwrpid_pkg::DUTY_W-1:0];
               dwrpid_pkg::REG_TARGET_LEFT: begin
                  target_left_ff <= $signed(csr_if.data[dwrpid_pkg::SPEED_W-1:0]);
                  clear_ff       <= 1'b1;
               end
               dwrpid_pkg::REG_TARGET_RIGHT: begin
                  target_right_ff <= $signed(csr_if.data[dwrpid_pkg::SPEED_W-1:0]);
                  clear_ff        <= 1'b1;
               end
               dwrpid_pkg::REG_RUN_ENABLE: begin
                  run_enable_ff <= csr_if.data[0];
                  clear_ff      <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // request capture: lanes start in the next cycle from the held copy
   always_ff @(posedge clock) begin
      if (req_take) begin
         speed_left_ff  <= req_if.speed_left;
         speed_right_ff <= req_if.speed_right;
         interval_ff    <= req_if.interval;
      end
      if (reset) begin
         busy_ff  <= 1'b0;
         start_ff <= 1'b0;
      end else begin
         start_ff <= req_take && run_enable_ff;
         if (req_take && run_enable_ff) begin
            busy_ff <= 1'b1;
         end else if (load_rsp) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // response register, loaded when empty or while a previous response drains
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         duty_left_ff  <= stat_left.duty;
         duty_right_ff <= stat_right.duty;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   dwrpid_lane #(.DUTY_TOP(DUTY_TOP)) u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lane_ctrl),
      .cfg    (cfg_ff),
      .target (target_left_ff),
      .speed  (speed_left_ff),
      .dt     (interval_ff),
      .stat   (stat_left)
   );

   dwrpid_lane #(.DUTY_TOP(DUTY_TOP)) u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lane_ctrl),
      .cfg    (cfg_ff),
      .target (target_right_ff),
      .speed  (speed_right_ff),
      .dt     (interval_ff),
      .stat   (stat_right)
   );

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.duty_left  = duty_left_ff;
   assign rsp_if.duty_right = duty_right_ff;

endmodule

FILE: design/dwrpid_chk.sv
module dwrpid_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [dwrpid_pkg::DUTY_W-1:0]     duty_left,
   input logic [dwrpid_pkg::DUTY_W-1:0]     duty_right
);

   // idle and empty right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("not idle after reset");

   // a stalled response keeps its duties
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(duty_left) && $stable(duty_right)))
      else $error("stalled response changed");

   // a response never appears in the cycle right after a request is taken
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response too early");

   // right after a taken request, a rising response must not come with ready high
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!rsp_valid || !req_ready || !$rose(rsp_valid)))
      else $error("request overlap");

endmodule

bind dual_wheel_rpm_pid dwrpid_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .duty_left  (rsp_if.duty_left),
   .duty_right (rsp_if.duty_right)
);
